// ===== hdl/sfna_pkg.sv =====
`timescale 1ns / 1ps

package sfna_pkg;

    localparam int SET_SIZE  = 1024;
    localparam int NUMBER_W  = 11;
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int NUM_WORDS = (SET_SIZE + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    localparam logic CMD_POP = 1'b0;
    localparam logic CMD_ADD = 1'b1;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [WIDX_W-1:0]    t_widx;
    typedef logic [BIT_W-1:0]     t_bit;

    typedef struct packed {
        logic take;
        logic locate;
        logic read;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

    function automatic t_word reset_word(input t_widx widx);
        t_word w;
        w = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            w[b] = ((int'(widx) * WORD_BITS + b) < SET_SIZE);
        end
        return w;
    endfunction

endpackage

// ===== hdl/sfna_ctrl.sv =====
`timescale 1ns / 1ps

module sfna_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  sfna_pkg::t_dp_status   i_status,
    output sfna_pkg::t_dp_cmd      o_ctl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOCATE,
        ST_READ,
        ST_UPDATE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   take;

    assign o_stall = (r_state != ST_IDLE) || i_status.out_busy;
    assign take    = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (take) n_state = ST_LOCATE;
            ST_LOCATE: n_state = ST_READ;
            ST_READ:   n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ctl.take   = take;
    assign o_ctl.locate = (r_state == ST_LOCATE);
    assign o_ctl.read   = (r_state == ST_READ);
    assign o_ctl.update = (r_state == ST_UPDATE);

endmodule

// ===== hdl/sfna_dp.sv =====
`timescale 1ns / 1ps

module sfna_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sfna_pkg::t_dp_cmd               i_ctl,
    input  logic                            i_cmd,
    input  logic [sfna_pkg::NUMBER_W-1:0]   i_number,
    input  logic                            i_stall,
    output sfna_pkg::t_dp_status            o_status,
    output logic                            o_valid,
    output logic [sfna_pkg::NUMBER_W-1:0]   o_smallest,
    output logic                            o_was_empty
);

    sfna_pkg::t_word                       r_mem [sfna_pkg::NUM_WORDS];
    logic [sfna_pkg::NUM_WORDS-1:0]        r_wvalid;
    logic [sfna_pkg::NUM_WORDS-1:0]        r_summary;

    logic                                  r_cmd;
    logic [sfna_pkg::NUMBER_W-1:0]         r_number;
    sfna_pkg::t_widx                       r_widx;
    sfna_pkg::t_bit                        r_bit;
    logic                                  r_hit;
    sfna_pkg::t_word                       r_rdata;
    logic                                  r_rvalid;

    logic                                  r_out_valid;
    logic [sfna_pkg::NUMBER_W-1:0]         r_smallest;
    logic                                  r_was_empty;

    sfna_pkg::t_widx                       f_widx;
    logic [31:0]                           num32;
    logic [31:0]                           idx32;
    logic                                  in_range;

    sfna_pkg::t_word                       word;
    sfna_pkg::t_word                       new_word;
    sfna_pkg::t_bit                        low_bit;
    logic [31:0]                           value32;
    logic                                  do_write;

    always_comb begin
        f_widx = '0;
        for (int w = sfna_pkg::NUM_WORDS - 1; w >= 0; w--) begin
            if (r_summary[w]) f_widx = sfna_pkg::t_widx'(w);
        end
    end

    assign num32    = 32'(r_number);
    assign idx32    = num32 - 32'd1;
    assign in_range = (num32 >= 32'd1) && (num32 <= 32'(sfna_pkg::SET_SIZE));

    always_comb begin
        word = r_rvalid ? r_rdata : sfna_pkg::reset_word(r_widx);
        low_bit = '0;
        for (int b = sfna_pkg::WORD_BITS - 1; b >= 0; b--) begin
            if (word[b]) low_bit = sfna_pkg::t_bit'(b);
        end
        if (r_cmd == sfna_pkg::CMD_POP) begin
            new_word = word & ~(sfna_pkg::t_word'(1) << low_bit);
        end else begin
            new_word = word | (sfna_pkg::t_word'(1) << r_bit);
        end
        value32  = (32'(r_widx) << sfna_pkg::BIT_W) + 32'(low_bit) + 32'd1;
        do_write = i_ctl.update && r_hit;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_cmd    <= i_cmd;
            r_number <= i_number;
        end
        if (i_ctl.locate) begin
            if (r_cmd == sfna_pkg::CMD_POP) begin
                r_widx <= f_widx;
                r_bit  <= '0;
                r_hit  <= |r_summary;
            end else begin
                r_widx <= idx32[sfna_pkg::BIT_W +: sfna_pkg::WIDX_W];
                r_bit  <= idx32[sfna_pkg::BIT_W-1:0];
                r_hit  <= in_range;
            end
        end
        if (i_ctl.read) begin
            r_rdata  <= r_mem[r_widx];
            r_rvalid <= r_wvalid[r_widx];
        end
        if (do_write) begin
            r_mem[r_widx] <= new_word;
        end
        if (i_ctl.update && (r_cmd == sfna_pkg::CMD_POP)) begin
            r_smallest  <= r_hit ? value32[sfna_pkg::NUMBER_W-1:0] : '0;
            r_was_empty <= !r_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid    <= '0;
            r_summary   <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (do_write) begin
                r_wvalid[r_widx]  <= 1'b1;
                r_summary[r_widx] <= |new_word;
            end
            if (i_ctl.update && (r_cmd == sfna_pkg::CMD_POP)) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_busy = r_out_valid && i_stall;
    assign o_valid           = r_out_valid;
    assign o_smallest        = r_smallest;
    assign o_was_empty       = r_was_empty;

endmodule

// ===== hdl/smallest_free_number_allocator.sv =====
// An accepted pop item passes through the locate, read and update states in turn
// before its result reaches the output register. A new item is taken only once the
// last is through: locate, word read and read-modify-write of the presence map run
// in turn on a single memory port, and a stalled result holds off the next item.
// Reset (synchronous, active low) restores every number to the set at once
// through per-word valid bits; items are accepted from the first cycle after.
`timescale 1ns / 1ps

module smallest_free_number_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_cmd,
    input  logic [sfna_pkg::NUMBER_W-1:0]   i_number,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [sfna_pkg::NUMBER_W-1:0]   o_smallest,
    output logic                            o_was_empty
);

    sfna_pkg::t_dp_cmd    ctl;
    sfna_pkg::t_dp_status status;

    sfna_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_ctl    (ctl)
    );

    sfna_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_cmd       (i_cmd),
        .i_number    (i_number),
        .i_stall     (i_stall),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_smallest  (o_smallest),
        .o_was_empty (o_was_empty)
    );

endmodule

// ===== verif/smallest_free_number_allocator_tb.sv =====
`timescale 1ns / 1ps

module smallest_free_number_allocator_tb;

    typedef logic [sfna_pkg::NUMBER_W-1:0] t_num;

    typedef struct packed {
        t_num smallest;
        logic was_empty;
    } t_pop_result;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_valid     = 1'b0;
    logic i_cmd       = sfna_pkg::CMD_POP;
    t_num i_number    = '0;
    logic i_stall     = 1'b0;
    logic o_stall;
    logic o_valid;
    t_num o_smallest;
    logic o_was_empty;

    t_pop_result expected_pops[$];
    t_pop_result oldest_pop;
    bit          number_present [1:sfna_pkg::SET_SIZE];
    int          present_total;
    bit          idle_on;
    int          fail_count;
    int          items_sent;
    int          pops_sent;
    int          empty_pops;
    int          adds_taken;
    int          adds_ignored;
    int          results_taken;
    int          results_seen;
    int          stall_left;

    smallest_free_number_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_number    (i_number),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_smallest  (o_smallest),
        .o_was_empty (o_was_empty)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic track_item(input logic cmd, input t_num num);
        t_pop_result r;
        int          n;
        if (cmd == sfna_pkg::CMD_POP) begin
            pops_sent++;
            n = 1;
            while (n <= sfna_pkg::SET_SIZE && !number_present[n]) n++;
            if (n <= sfna_pkg::SET_SIZE) begin
                r.smallest  = n[sfna_pkg::NUMBER_W-1:0];
                r.was_empty = 1'b0;
                number_present[n] = 1'b0;
                present_total--;
            end else begin
                r.smallest  = '0;
                r.was_empty = 1'b1;
                empty_pops++;
            end
            expected_pops.push_back(r);
        end else begin
            n = int'(num);
            if (n >= 1 && n <= sfna_pkg::SET_SIZE && !number_present[n]) begin
                number_present[n] = 1'b1;
                present_total++;
                adds_taken++;
            end else begin
                adds_ignored++;
            end
        end
    endtask

    task automatic send_item(input logic cmd, input t_num num);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid  <= 1'b0;
            i_cmd    <= 1'($urandom_range(0, 1));
            i_number <= t_num'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_cmd    <= cmd;
        i_number <= num;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        track_item(cmd, num);
        items_sent++;
    endtask

    task automatic pop_number();
        t_num junk;
        junk = t_num'($urandom);
        send_item(sfna_pkg::CMD_POP, junk);
    endtask

    task automatic add_number(input t_num num);
        send_item(sfna_pkg::CMD_ADD, num);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_pops.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_num pick_number(input int span);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return t_num'($urandom_range(sfna_pkg::SET_SIZE + 1,
                                                  (1 << sfna_pkg::NUMBER_W) - 1));
            2, 3, 4: return t_num'($urandom_range(1, sfna_pkg::SET_SIZE));
            default: return t_num'($urandom_range(1, span));
        endcase
    endfunction

    task automatic test_first_pops();
        idle_on = 1'b0;
        repeat (3) pop_number();
    endtask

    task automatic test_ignored_adds();
        idle_on = 1'b1;
        add_number('0);
        add_number('1);
        add_number(t_num'(sfna_pkg::SET_SIZE + 1));
        add_number(t_num'(sfna_pkg::SET_SIZE));
        add_number(t_num'(500));
        pop_number();
    endtask

    task automatic test_add_back();
        add_number(t_num'(2));
        add_number(t_num'(1));
        pop_number();
        pop_number();
        send_item(sfna_pkg::CMD_POP, t_num'(1));
        add_number(t_num'(3));
        add_number(t_num'(3));
        pop_number();
        pop_number();
        add_number(t_num'(64));
        add_number(t_num'(65));
        pop_number();
    endtask

    task automatic test_random_traffic(input int count, input int pop_pct, input int span);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(1, 100) <= pop_pct) pop_number();
            else add_number(pick_number(span));
        end
    endtask

    task automatic test_pause_until_drained();
        idle_on = 1'b0;
        repeat (4) pop_number();
        wait_for_results();
        pop_number();
        add_number(pick_number(sfna_pkg::SET_SIZE));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_taken++;
            if (expected_pops.size() == 0) begin
                $error("unexpected item: smallest %0d, was_empty %0b", o_smallest, o_was_empty);
                fail_count++;
            end else begin
                oldest_pop = expected_pops.pop_front();
                if (o_smallest !== oldest_pop.smallest) begin
                    $error("smallest: expected %0d, actual %0d",
                           oldest_pop.smallest, o_smallest);
                    fail_count++;
                end
                if (o_was_empty !== oldest_pop.was_empty) begin
                    $error("was_empty: expected %0b, actual %0b",
                           oldest_pop.was_empty, o_was_empty);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (results_seen != results_taken) begin
            results_seen = results_taken;
            stall_left   = idle_on ? $urandom_range(0, 11) : 0;
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL smallest_free_number_allocator");
        $finish;
    end

    initial begin
        for (int n = 1; n <= sfna_pkg::SET_SIZE; n++) number_present[n] = 1'b1;
        present_total = sfna_pkg::SET_SIZE;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_first_pops();
        test_ignored_adds();
        test_add_back();
        test_random_traffic(300, 60, 256);
        test_pause_until_drained();
        test_random_traffic(320, 45, 64);

        wait_for_results();
        repeat (12) @(posedge i_clk);
        $display("Sent %0d items: %0d pops, %0d of them on an empty set.",
                 items_sent, pops_sent, empty_pops);
        $display("Adds: %0d put a number back, %0d left the set unchanged.",
                 adds_taken, adds_ignored);
        if (fail_count == 0) begin
            $display("PASS smallest_free_number_allocator");
        end else begin
            $display("FAIL smallest_free_number_allocator");
        end
        $finish;
    end

endmodule
